[sv/marker_insert_extract_translate_assert.svh]
// Assertion macros used by the marker insert datapath
`ifndef MARKER_INSERT_EXTRACT_TRANSLATE_ASSERT_SVH
`define MARKER_INSERT_EXTRACT_TRANSLATE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define MIET_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication outside reset
`define MIET_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[sv/miet_pkg.sv]
// ----------------------------------------------------------------------------
// miet_pkg
// Types and constants shared by the marker insert extraction blocks.
// ----------------------------------------------------------------------------
`default_nettype none
package miet_pkg;
   localparam int BaseW = 3;
   localparam logic [2:0] BaseOther = 3'd4;
   localparam logic [1:0] StFound = 2'd0;
   localparam logic [1:0] StNoInsert = 2'd1;
   localparam logic [1:0] StNoMatch = 2'd2;
   localparam logic [1:0] StTooLong = 2'd3;
   localparam logic [6:0] AaUnknown = 7'h58;

   localparam logic [1:0] RegFirst = 2'd0;
   localparam logic [1:0] RegFirstLen = 2'd1;
   localparam logic [1:0] RegSecond = 2'd2;
   localparam logic [1:0] RegSecondLen = 2'd3;

   typedef struct packed {
      logic [2:0] base;
      logic       read_end;
   } req_type;

   typedef struct packed {
      logic       is_summary;
      logic [6:0] amino_acid;
      logic [1:0] status;
      logic [7:0] insert_length;
      logic       final_item;
   } rsp_type;

   typedef enum logic [2:0] {
      S_LOAD, S_RD0, S_RD1, S_RD2, S_WAIT, S_EMIT, S_SUM
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       rd_en;
      logic [1:0] rd_slot;
      logic       rd_start;
      logic       emit_aa;
      logic       emit_sum;
      logic       clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       read_end;
      logic       translate;
      logic       more_codons;
      logic       rsp_busy;
   } sts_type;

   // Standard genetic code, index 16*b0 + 4*b1 + b2
   function automatic logic [6:0] codon_letter(input logic [5:0] idx);
      logic [7:0] c;
      begin
         case (idx)
            6'd0: c = "K"; 6'd1: c = "N"; 6'd2: c = "K"; 6'd3: c = "N";
            6'd4, 6'd5, 6'd6, 6'd7: c = "T";
            6'd8: c = "R"; 6'd9: c = "S"; 6'd10: c = "R"; 6'd11: c = "S";
            6'd12: c = "I"; 6'd13: c = "I"; 6'd14: c = "M"; 6'd15: c = "I";
            6'd16: c = "Q"; 6'd17: c = "H"; 6'd18: c = "Q"; 6'd19: c = "H";
            6'd20, 6'd21, 6'd22, 6'd23: c = "P";
            6'd24, 6'd25, 6'd26, 6'd27: c = "R";
            6'd28, 6'd29, 6'd30, 6'd31: c = "L";
            6'd32: c = "E"; 6'd33: c = "D"; 6'd34: c = "E"; 6'd35: c = "D";
            6'd36, 6'd37, 6'd38, 6'd39: c = "A";
            6'd40, 6'd41, 6'd42, 6'd43: c = "G";
            6'd44, 6'd45, 6'd46, 6'd47: c = "V";
            6'd48: c = "*"; 6'd49: c = "Y"; 6'd50: c = "*"; 6'd51: c = "Y";
            6'd52, 6'd53, 6'd54, 6'd55: c = "S";
            6'd56: c = "*"; 6'd57: c = "C"; 6'd58: c = "W"; 6'd59: c = "C";
            6'd60: c = "L"; 6'd61: c = "F"; 6'd62: c = "L";
            default: c = "F";
         endcase
         codon_letter = c[6:0];
      end
   endfunction
endpackage
`default_nettype wire

[sv/miet_ram.sv]
// ----------------------------------------------------------------------------
// miet_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module miet_ram #(
   parameter int Width = 3,
   parameter int Depth = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[sv/miet_ctrl.sv]
// ----------------------------------------------------------------------------
// miet_ctrl
// Sequencer: loads bases, then reads codons back and emits items.
// ----------------------------------------------------------------------------
`default_nettype none
module miet_ctrl
   import miet_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.read_end) begin
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            // decide the outcome once the last base has been recorded
            if (sts.translate && sts.more_codons) begin
               cmd.rd_en = 1'b1;
               cmd.rd_slot = 2'd0;
               cmd.rd_start = 1'b1;
               state_in = S_RD0;
            end else begin
               state_in = S_SUM;
            end
         end
         S_RD0: begin
            cmd.rd_en = 1'b1;
            cmd.rd_slot = 2'd1;
            state_in = S_RD1;
         end
         S_RD1: begin
            cmd.rd_en = 1'b1;
            cmd.rd_slot = 2'd2;
            state_in = S_RD2;
         end
         S_RD2: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!sts.rsp_busy) begin
               cmd.emit_aa = 1'b1;
               if (sts.more_codons) begin
                  cmd.rd_en = 1'b1;
                  cmd.rd_slot = 2'd0;
                  state_in = S_RD0;
               end else begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (!sts.rsp_busy) begin
               cmd.emit_sum = 1'b1;
               cmd.clear = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end
endmodule
`default_nettype wire

[sv/miet_dpath.sv]
// ----------------------------------------------------------------------------
// miet_dpath
// Datapath: read store, marker matching, codon fetch and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "marker_insert_extract_translate_assert.svh"
module miet_dpath
   import miet_pkg::*;
#(
   parameter int MaxReadLen = 128,
   parameter int MaxMarkerLen = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire logic [31:0] first_marker,
   input  wire logic [4:0]  first_marker_len,
   input  wire logic [31:0] second_marker,
   input  wire logic [4:0]  second_marker_len,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);
   localparam int AddrW = $clog2(MaxReadLen);
   localparam int MkCap = (MaxMarkerLen < 16) ? MaxMarkerLen : 16;
   localparam logic [7:0] MaxLen8 = 8'(MaxReadLen);

   logic [47:0] win_ff, win_in;
   logic [7:0]  pos_ff;
   logic        ff1_ff, seen2_ff, end_found_ff, ovf_ff;
   logic [7:0]  ins_start_ff, ins_end_ff;
   logic [7:0]  rd_ptr_ff;
   logic        fetch_on_ff;
   logic [2:0]  b0_ff, b1_ff;
   logic [1:0]  slot_ff;
   logic        slot_vld_ff;
   logic [6:0]  aa_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [2:0]  rd_data;
   logic [2:0]  base_eff;
   logic [4:0]  l1, l2;
   logic [7:0]  pos_next;
   logic        m1, m2, store_ok;
   logic [7:0]  s2;

   // clamp the marker lengths
   function automatic logic [4:0] eff_len(input logic [4:0] len);
      logic [4:0] r;
      begin
         r = (len == 5'd0) ? 5'd1 : len;
         if (r > 5'(MkCap)) r = 5'(MkCap);
         eff_len = r;
      end
   endfunction

   // compare the newest bases of the window against a marker
   function automatic logic win_match(input logic [47:0] w, input logic [31:0] mk,
                                      input logic [4:0] len, input logic [7:0] stored);
      logic ok;
      begin
         ok = (stored >= {3'd0, len});
         for (int i = 0; i < 16; i++) begin
            if (5'(i) < len) begin
               if (w[3*(32'(len)-1-i) +: 3] != {1'b0, mk[2*i +: 2]}) ok = 1'b0;
            end
         end
         win_match = ok;
      end
   endfunction

   assign base_eff = (req_data.base > BaseOther) ? BaseOther : req_data.base;
   assign l1 = eff_len(first_marker_len);
   assign l2 = eff_len(second_marker_len);
   assign store_ok = cmd.load && (pos_ff < MaxLen8);
   assign pos_next = pos_ff + 8'd1;
   assign win_in = {win_ff[44:0], base_eff};
   assign m1 = win_match(win_in, first_marker, l1, pos_next);
   assign m2 = win_match(win_in, second_marker, l2, pos_next);
   assign s2 = pos_next - {3'd0, l2};

   miet_ram #(.Width(BaseW), .Depth(MaxReadLen)) u_store (
      .clock  (clock),
      .wr_en  (store_ok),
      .wr_addr(pos_ff[AddrW-1:0]),
      .wr_data(base_eff),
      .rd_en  (cmd.rd_en),
      .rd_addr(cmd.rd_start ? ins_start_ff[AddrW-1:0] : rd_ptr_ff[AddrW-1:0]),
      .rd_data(rd_data)
   );

   // per-read tracking state
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         win_ff <= '0;
         pos_ff <= '0;
         ff1_ff <= 1'b0;
         seen2_ff <= 1'b0;
         end_found_ff <= 1'b0;
         ovf_ff <= 1'b0;
         ins_start_ff <= '0;
         ins_end_ff <= '0;
      end else if (cmd.load) begin
         if (!store_ok) begin
            ovf_ff <= 1'b1;
         end else begin
            win_ff <= win_in;
            pos_ff <= pos_next;
            if (!ff1_ff && m1) begin
               ff1_ff <= 1'b1;
               ins_start_ff <= pos_next;
            end
            if (m2) begin
               seen2_ff <= 1'b1;
               if (!end_found_ff && (ff1_ff || m1)
                   && s2 >= ((ff1_ff) ? ins_start_ff : pos_next)) begin
                  end_found_ff <= 1'b1;
                  ins_end_ff <= s2;
               end
            end
         end
      end
   end

   // mark that codon fetch has begun for this read
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         fetch_on_ff <= 1'b0;
      end else if (cmd.rd_en) begin
         fetch_on_ff <= 1'b1;
      end
   end

   // codon fetch: pointer, collected bases, table lookup
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= 1'b0;
         rd_ptr_ff <= '0;
      end else begin
         slot_vld_ff <= cmd.rd_en;
         if (cmd.rd_en) begin
            rd_ptr_ff <= (cmd.rd_start ? ins_start_ff : rd_ptr_ff) + 8'd1;
         end
      end
      slot_ff <= cmd.rd_slot;
      if (slot_vld_ff) begin
         case (slot_ff)
            2'd0: b0_ff <= rd_data;
            2'd1: b1_ff <= rd_data;
            default: begin
               if (b0_ff[2] || b1_ff[2] || rd_data[2]) begin
                  aa_ff <= AaUnknown;
               end else begin
                  aa_ff <= codon_letter({b0_ff[1:0], b1_ff[1:0], rd_data[1:0]});
               end
            end
         endcase
      end
   end

   logic       translate;
   logic [1:0] sum_status;
   assign translate = !ovf_ff && ff1_ff && seen2_ff && end_found_ff
                      && (ins_end_ff > ins_start_ff);
   always_comb begin
      if (ovf_ff) sum_status = StTooLong;
      else if (!(ff1_ff && seen2_ff)) sum_status = StNoMatch;
      else if (!translate) sum_status = StNoInsert;
      else sum_status = StFound;
   end

   // status to the controller; rd_ptr is the next codon start while emitting
   assign sts.read_end = req_data.read_end;
   assign sts.translate = translate;
   assign sts.more_codons = fetch_on_ff
      ? ({1'b0, rd_ptr_ff} + 9'd3 <= {1'b0, ins_end_ff})
      : ({1'b0, ins_start_ff} + 9'd3 <= {1'b0, ins_end_ff});
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_aa || cmd.emit_sum) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_aa) begin
         rsp_ff <= '{is_summary: 1'b0, amino_acid: aa_ff, status: StFound,
                     insert_length: 8'd0, final_item: 1'b0};
      end else if (cmd.emit_sum) begin
         rsp_ff <= '{is_summary: 1'b1, amino_acid: 7'd0, status: sum_status,
                     insert_length: translate ? (ins_end_ff - ins_start_ff) : 8'd0,
                     final_item: 1'b1};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `MIET_ASSERT_IMP(a_no_emit_busy, clock, reset, rsp_valid_ff && !rsp_ready, !(cmd.emit_aa || cmd.emit_sum))
   `MIET_ASSERT_IMP(a_pos_bound, clock, reset, 1'b1, pos_ff <= MaxLen8)
   `MIET_ASSERT_IMP(a_end_after_start, clock, reset, end_found_ff, ff1_ff && ins_end_ff >= ins_start_ff)
   `MIET_ASSERT_NEXT(a_clear, clock, reset, cmd.clear, pos_ff == 8'd0 && !ovf_ff)
endmodule
`default_nettype wire

[sv/marker_insert_extract_translate.sv]
// ----------------------------------------------------------------------------
// marker_insert_extract_translate
// Stores a read, finds the insert between two markers and translates it.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | req_data (base, read_end)
// rsp     | out       | rsp_valid / rsp_ready  | rsp_data (one item)
// csr     | in        | APB psel/penable/pready| first/second marker, lengths
//
// One base per cycle while loading. The last base is followed by a decision
// step, then per codon three store reads through the single read port and one
// emit, and then the summary. Reset is synchronous and clears all control
// state. A stalled rsp_ready holds the sequencer in its emit or summary step.
`default_nettype none
module marker_insert_extract_translate
   import miet_pkg::*;
#(
   parameter int MAX_READ_LEN = 128,
   parameter int MAX_MARKER_LEN = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   logic [31:0] first_ff, second_ff;
   logic [4:0]  first_len_ff, second_len_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic [1:0]  reg_idx;

   assign pready = 1'b1;
   assign reg_idx = paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         first_len_ff <= 5'd1;
         second_ff <= '0;
         second_len_ff <= 5'd1;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            RegFirst: first_ff <= pwdata;
            RegFirstLen: first_len_ff <= pwdata[4:0];
            RegSecond: second_ff <= pwdata;
            RegSecondLen: second_len_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_idx)
         RegFirst: prdata = first_ff;
         RegFirstLen: prdata = {27'd0, first_len_ff};
         RegSecond: prdata = second_ff;
         RegSecondLen: prdata = {27'd0, second_len_ff};
         default: prdata = '0;
      endcase
   end

   miet_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   miet_dpath #(.MaxReadLen(MAX_READ_LEN), .MaxMarkerLen(MAX_MARKER_LEN)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .first_marker     (first_ff),
      .first_marker_len (first_len_ff),
      .second_marker    (second_ff),
      .second_marker_len(second_len_ff),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );
endmodule
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives bases into the marker insert block, predicts the translated insert
// and read summary for every read, and compares each output item with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import miet_pkg::*;

   localparam int ReadMax = 128;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   marker_insert_extract_translate dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor copy of registers and per-read state
   logic [31:0] mk1, mk2;
   logic [4:0]  mk1_len, mk2_len;
   logic [2:0]  bases_seen [ReadMax];
   logic [47:0] window;
   int          pos;
   bit          got_first, got_second, got_end, too_long;
   int          ins_start, ins_end;

   rsp_type     pending_items [$];
   int          errors = 0;
   int          send_idle = 0;
   int          take_idle = 0;
   bit          hold_off = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb failed");
      $finish;
   end

   function automatic int clamp_len(logic [4:0] l);
      if (l < 1) return 1;
      if (l > 16) return 16;
      return l;
   endfunction

   function automatic bit tail_matches(logic [31:0] mk, int l);
      if (pos < l) return 0;
      for (int i = 0; i < l; i++)
         if (window[3*(l-1-i) +: 3] != {1'b0, mk[2*i +: 2]}) return 0;
      return 1;
   endfunction

   function automatic logic [6:0] amino_of(logic [2:0] b0, logic [2:0] b1, logic [2:0] b2);
      string code;
      code = "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";
      if (b0 > 3 || b1 > 3 || b2 > 3) return AaUnknown;
      return 7'(code[b0*16 + b1*4 + b2]);
   endfunction

   function automatic rsp_type make_summary(logic [1:0] st, logic [7:0] len);
      rsp_type r;
      r = '0;
      r.is_summary = 1;
      r.status = st;
      r.insert_length = len;
      r.final_item = 1;
      return r;
   endfunction

   // append one expected item to the tail of the queue
   function automatic void expect_item(rsp_type r);
      pending_items = {pending_items, r};
   endfunction

   function automatic void clear_read_state();
      window = '0; pos = 0; got_first = 0; got_second = 0; got_end = 0;
      too_long = 0; ins_start = 0; ins_end = 0;
   endfunction

   // advance the predictor by one base and queue what the read end produces
   task automatic predict_base(logic [2:0] b_in, logic last);
      logic [2:0] b;
      int l1, l2, s;
      rsp_type r;
      b = (b_in > 4) ? 3'd4 : b_in;
      if (pos >= ReadMax) too_long = 1;
      else begin
         l1 = clamp_len(mk1_len);
         l2 = clamp_len(mk2_len);
         bases_seen[pos] = b;
         window = {window[44:0], b};
         pos++;
         if (!got_first && tail_matches(mk1, l1)) begin
            got_first = 1;
            ins_start = pos;
         end
         if (tail_matches(mk2, l2)) begin
            s = pos - l2;
            got_second = 1;
            if (got_first && !got_end && s >= ins_start) begin
               got_end = 1;
               ins_end = s;
            end
         end
      end
      if (!last) return;
      if (too_long) expect_item(make_summary(StTooLong, 0));
      else if (!(got_first && got_second)) expect_item(make_summary(StNoMatch, 0));
      else if (!got_end || ins_end <= ins_start)
         expect_item(make_summary(StNoInsert, 0));
      else begin
         for (int i = ins_start; i + 3 <= ins_end; i += 3) begin
            r = '0;
            r.amino_acid = amino_of(bases_seen[i], bases_seen[i+1], bases_seen[i+2]);
            expect_item(r);
         end
         expect_item(make_summary(StFound, 8'(ins_end - ins_start)));
      end
      clear_read_state();
   endtask

   // send one base item, with random idle cycles ahead of it; returns at the
   // accepting edge and leaves valid to the next falling edge
   task automatic send_base(logic [2:0] b, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{base: b, read_end: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_base(b, last);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         RegFirst:     mk1 = val;
         RegFirstLen:  mk1_len = val[4:0];
         RegSecond:    mk2 = val;
         RegSecondLen: mk2_len = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // drop valid, wait for all results, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending_items.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_markers(logic [31:0] a, logic [4:0] al, logic [31:0] b, logic [4:0] bl);
      drain();
      write_reg(RegFirst, a);
      write_reg(RegFirstLen, {27'd0, al});
      write_reg(RegSecond, b);
      write_reg(RegSecondLen, {27'd0, bl});
   endtask

   // send marker bases from a packed value
   task automatic send_marker(logic [31:0] mk, int l);
      for (int i = 0; i < l; i++) send_base({1'b0, mk[2*i +: 2]}, 0);
   endtask

   task automatic send_random_bases(int n, int other_pct);
      for (int i = 0; i < n; i++)
         send_base(($urandom_range(99) < other_pct) ? 3'($urandom_range(7, 4))
                                                    : 3'($urandom_range(3)), 0);
   endtask

   // leading bases, marker1, insert, marker2, trailer as one read
   task automatic send_framed_read(int ins_len, int other_pct);
      int l1, l2;
      l1 = clamp_len(mk1_len);
      l2 = clamp_len(mk2_len);
      send_random_bases($urandom_range(3), 5);
      send_marker(mk1, l1);
      send_random_bases(ins_len, other_pct);
      send_marker(mk2, l2);
      send_random_bases($urandom_range(2), 5);
      send_base(3'($urandom_range(3)), 1);
   endtask

   // a run of consecutive codons from a random start, then marker2 and an unknown last base
   task automatic test_codon_table();
      int c0;
      c0 = $urandom_range(63);
      set_markers(32'h0, 5'd1, 32'hFF, 5'd4);
      send_base(3'd0, 0);
      for (int k = 0; k < 12; k++) begin
         int c;
         c = (c0 + k) % 64;
         send_base(3'(c >> 4), 0);
         send_base(3'((c >> 2) & 3), 0);
         send_base(3'(c & 3), 0);
      end
      send_marker(32'hFF, 4);
      send_base(3'd7, 1);
   endtask

   // no marker, marker2 first, empty insert, unknown base, too long, clamping
   task automatic test_special_reads();
      set_markers(32'h1, 5'd2, 32'h2, 5'd1);
      send_base(3'd3, 0); send_base(3'd3, 1);
      send_base(3'd2, 0); send_base(3'd1, 0); send_base(3'd0, 1);
      send_base(3'd1, 0); send_base(3'd0, 0); send_base(3'd2, 1);
      send_base(3'd1, 0); send_base(3'd0, 0); send_base(3'd5, 0);
      send_base(3'd0, 0); send_base(3'd1, 0); send_base(3'd2, 1);
      send_random_bases(ReadMax, 10);
      send_base(3'd0, 1);
      set_markers(32'h0, 5'd0, 32'h0, 5'd31);
      send_framed_read(7, 20);
   endtask

   // well-formed reads with random markers and lengths, plus noise reads
   task automatic test_random_reads(int count);
      for (int r = 0; r < count; r++) begin
         if (r % 4 == 0)
            set_markers($urandom, 5'($urandom_range(1, 8)), $urandom,
                        5'($urandom_range(1, 8)));
         if ($urandom_range(9) < 8) send_framed_read($urandom_range(0, 12), 8);
         else begin
            send_random_bases($urandom_range(0, 12), 20);
            send_base(3'($urandom_range(7)), 1);
         end
      end
   endtask

   // stall the result side for a long stretch while more bases are offered
   task automatic test_output_stall();
      set_markers(32'h0, 5'd1, 32'h3, 5'd1);
      hold_off = 1;
      repeat (2) begin
         send_base(3'd0, 0);
         send_random_bases(10, 0);
         send_base(3'd3, 0);
         send_base(3'd3, 1);
      end
   endtask

   // drive the receiver side
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_ready <= 0;
         repeat (400) @(negedge clock);
         hold_off = 0;
      end else
         rsp_ready <= ($urandom_range(99) >= take_idle);
   end

   // compare each result item with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_items.size() == 0) begin
            $error("unexpected item %p", rsp_data);
            errors++;
         end else begin
            want = pending_items.pop_front();
            if (rsp_data.is_summary !== want.is_summary) begin
               $error("is_summary exp %0d got %0d", want.is_summary, rsp_data.is_summary);
               errors++;
            end
            if (rsp_data.amino_acid !== want.amino_acid) begin
               $error("amino_acid exp %0h got %0h", want.amino_acid, rsp_data.amino_acid);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.insert_length !== want.insert_length) begin
               $error("insert_length exp %0d got %0d", want.insert_length,
                      rsp_data.insert_length);
               errors++;
            end
            if (rsp_data.final_item !== want.final_item) begin
               $error("final_item exp %0d got %0d", want.final_item, rsp_data.final_item);
               errors++;
            end
         end
      end
   end

   initial begin
      reset = 1; req_valid = 0; req_data = '0; rsp_ready = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      mk1 = 0; mk1_len = 1; mk2 = 0; mk2_len = 1;
      clear_read_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_codon_table();
      test_special_reads();
      send_idle = 27; take_idle = 50;
      test_random_reads(2);
      send_idle = 50; take_idle = 27;
      test_random_reads(1);
      send_idle = 0; take_idle = 0;
      test_random_reads(1);
      test_output_stall();
      drain();
      repeat (50) @(negedge clock);
      if (errors == 0 && pending_items.size() == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end
endmodule
`default_nettype wire
